>>> hdl/mrc_pkg.sv
// Shared types, codes and the CRC-16/MODBUS byte update for the Modbus response checker.
package mrc_pkg;

   typedef enum logic [1:0] {
      KIND_READ_HOLDING = 2'd0,
      KIND_WRITE_SINGLE = 2'd1,
      KIND_WRITE_MULTI  = 2'd2
   } kind_type;

   localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
   localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;
   localparam logic [7:0]  FC_WRITE_MULTI  = 8'h10;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [8:0]  POS_MAX       = 9'd511;
   localparam logic [9:0]  READ_OVERHEAD = 10'd5;
   localparam logic [9:0]  WORD_LIMIT    = 10'd4;
   localparam logic [8:0]  READ_MIN_LAST = 9'd4;
   localparam logic [8:0]  WRITE_LAST    = 9'd7;

   localparam logic RESULT_WORD    = 1'b0;
   localparam logic RESULT_VERDICT = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] word_value;
      logic [15:0] address_field;
      logic        frame_ok;
      logic        is_last;
   } rsp_item_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> hdl/mrc_req_if.sv
// Input channel interface: one received frame byte with its last-byte mark.
interface mrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> hdl/mrc_rsp_if.sv
// Result channel interface: a tentative register word or a final frame verdict.
interface mrc_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] word_value;
   logic [15:0] address_field;
   logic        frame_ok;
   logic        is_last;

   modport source (output valid, output kind, output word_value, output address_field,
                   output frame_ok, output is_last, input ready);
   modport sink   (input valid, input kind, input word_value, input address_field,
                   input frame_ok, input is_last, output ready);
endinterface

>>> hdl/modbus_response_checker.sv
// Top level of the Modbus RTU response checker with CRC-16/MODBUS.
//
//   Channel   Direction  Contents
//   req_if    in         data_byte, last_byte
//   rsp_if    out        kind, word_value, address_field, frame_ok, is_last
//   csr_*     in         expected_kind (2 bits), write enable and data
//
// One byte item is accepted every cycle while results are not stalled; a byte that
// yields a result passes from the input register through the combinational CRC and
// position logic into the result register, which presents it. A stalled result
// holds the engine and the input register, so at most two items sit inside the
// block. Reset is synchronous and returns the frame state and expected_kind to
// their initial values.
module modbus_response_checker (
   input  logic       clock,
   input  logic       reset,
   mrc_req_if.sink    req_if,
   mrc_rsp_if.source  rsp_if,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data
);
   import mrc_pkg::*;

   logic [1:0]   kind_ff;
   logic         advance;
   logic         stage_valid;
   req_item_type stage_item;
   logic         fire;
   logic         result_valid;
   rsp_item_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_READ_HOLDING;
      end else if (csr_write_enable) begin
         kind_ff <= csr_write_data;
      end
   end

   mrc_input_stage u_input_stage (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   assign fire = stage_valid && advance;

   mrc_frame_engine u_frame_engine (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .item          (stage_item),
      .expected_kind (kind_ff),
      .result_valid  (result_valid),
      .result        (result)
   );

   mrc_output_stage u_output_stage (
      .clock      (clock),
      .reset      (reset),
      .load_valid (fire && result_valid),
      .load_item  (result),
      .advance    (advance),
      .rsp_if     (rsp_if)
   );

   a_last_gives_verdict: assert property (@(posedge clock) disable iff (reset)
      (fire && stage_item.last_byte) |=> (rsp_if.valid && rsp_if.kind == RESULT_VERDICT))
      else $error("last byte did not produce a verdict");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (rsp_if.valid && !rsp_if.ready))
      else $error("input stalled without a blocked result");

   a_word_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.kind == RESULT_WORD)
         |-> (!rsp_if.frame_ok && !rsp_if.is_last && rsp_if.address_field == 16'h0000))
      else $error("register word item carries verdict fields");
endmodule

>>> hdl/mrc_input_stage.sv
// Input register that captures one byte item and holds it until the engine takes it.
module mrc_input_stage (
   input  logic                  clock,
   input  logic                  reset,
   mrc_req_if.sink               req_if,
   input  logic                  advance,
   output logic                  stage_valid,
   output mrc_pkg::req_item_type stage_item
);
   import mrc_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         accept;

   assign req_if.ready = !valid_ff || advance;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.data_byte <= req_if.data_byte;
         item_ff.last_byte <= req_if.last_byte;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;
endmodule

>>> hdl/mrc_frame_engine.sv
// Frame state, CRC update, position decode and result formation, one byte per cycle while fire is high.
module mrc_frame_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  mrc_pkg::req_item_type item,
   input  logic [1:0]            expected_kind,
   output logic                  result_valid,
   output mrc_pkg::rsp_item_type result
);
   import mrc_pkg::*;

   logic [8:0]  pos_ff,    pos_in;
   logic [15:0] crc_ff,    crc_in;
   logic [7:0]  count_ff,  count_in;
   logic        match_ff,  match_in;
   logic [7:0]  pend_ff,   pend_in;
   logic [15:0] first_ff,  first_in;
   logic [15:0] second_ff, second_in;

   logic        is_read;
   logic        valid_kind;
   logic        is_write;
   logic [7:0]  code;
   logic        word_ready;
   logic [9:0]  len;
   logic        crc_ok;
   logic        frame_ok;
   logic [7:0]  b;

   assign b = item.data_byte;

   always_comb begin
      case (expected_kind)
         KIND_READ_HOLDING: begin code = FC_READ_HOLDING; valid_kind = 1'b1; end
         KIND_WRITE_SINGLE: begin code = FC_WRITE_SINGLE; valid_kind = 1'b1; end
         KIND_WRITE_MULTI:  begin code = FC_WRITE_MULTI;  valid_kind = 1'b1; end
         default:           begin code = 8'h00;           valid_kind = 1'b0; end
      endcase
   end

   assign is_read  = (expected_kind == KIND_READ_HOLDING);
   assign is_write = valid_kind && !is_read;

   always_comb begin
      crc_in     = crc_update(crc_ff, b);
      match_in   = match_ff;
      count_in   = count_ff;
      pend_in    = pend_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      word_ready = 1'b0;

      if (pos_ff == 9'd1) begin
         match_in = valid_kind && (b == code);
      end

      if (is_read) begin
         if (pos_ff == 9'd2) begin
            count_in = b;
         end else if (pos_ff >= 9'd3) begin
            if (pos_ff[0]) begin
               pend_in = b;
            end else if ({1'b0, pos_ff} < ({2'b00, count_ff} + WORD_LIMIT)) begin
               word_ready = 1'b1;
            end
         end
      end else begin
         if (pos_ff == 9'd2 || pos_ff == 9'd4) begin
            pend_in = b;
         end else if (pos_ff == 9'd3) begin
            first_in = {pend_ff, b};
         end else if (pos_ff == 9'd5) begin
            second_in = {pend_ff, b};
         end
      end

      pos_in = (pos_ff != POS_MAX) ? pos_ff + 9'd1 : pos_ff;

      len    = {1'b0, pos_ff} + 10'd1;
      crc_ok = (crc_in == 16'h0000);
      if (is_read) begin
         frame_ok = (pos_ff >= READ_MIN_LAST) && crc_ok && match_in
                    && (len == ({2'b00, count_in} + READ_OVERHEAD));
      end else begin
         frame_ok = is_write && (pos_ff == WRITE_LAST) && crc_ok && match_in;
      end

      result_valid = item.last_byte || word_ready;
      if (item.last_byte) begin
         result.kind          = RESULT_VERDICT;
         result.word_value    = is_write ? second_in : 16'h0000;
         result.address_field = is_write ? first_in : 16'h0000;
         result.frame_ok      = frame_ok;
         result.is_last       = 1'b1;
      end else begin
         result.kind          = RESULT_WORD;
         result.word_value    = {pend_ff, b};
         result.address_field = 16'h0000;
         result.frame_ok      = 1'b0;
         result.is_last       = 1'b0;
      end

      if (item.last_byte) begin
         pos_in    = 9'd0;
         crc_in    = CRC_INIT;
         count_in  = 8'h00;
         match_in  = 1'b0;
         pend_in   = 8'h00;
         first_in  = 16'h0000;
         second_in = 16'h0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 9'd0;
         crc_ff    <= CRC_INIT;
         count_ff  <= 8'h00;
         match_ff  <= 1'b0;
         pend_ff   <= 8'h00;
         first_ff  <= 16'h0000;
         second_ff <= 16'h0000;
      end else if (fire) begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         count_ff  <= count_in;
         match_ff  <= match_in;
         pend_ff   <= pend_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end
endmodule

>>> hdl/mrc_output_stage.sv
// Result register that holds one result item until the sink takes it.
module mrc_output_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   input  mrc_pkg::rsp_item_type load_item,
   output logic                  advance,
   mrc_rsp_if.source             rsp_if
);
   import mrc_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign advance  = !valid_ff || rsp_if.ready;
   assign valid_in = advance ? load_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load_valid) begin
         item_ff <= load_item;
      end
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.kind          = item_ff.kind;
   assign rsp_if.word_value    = item_ff.word_value;
   assign rsp_if.address_field = item_ff.address_field;
   assign rsp_if.frame_ok      = item_ff.frame_ok;
   assign rsp_if.is_last       = item_ff.is_last;
endmodule
